// ===== rtl/square_matrix_rotate_flip_defines.svh =====
// Assertion macros shared by the matrix rotate/flip block.
`ifndef SQUARE_MATRIX_ROTATE_FLIP_DEFINES_SVH
`define SQUARE_MATRIX_ROTATE_FLIP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, disabled during reset.
`define SMRF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, disabled during reset.
`define SMRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define SMRF_ASSERT_IMP(label, ante, cons)
`define SMRF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/smrf_pkg.sv =====
// Shared constants, types and helper functions of the matrix rotate/flip block.
package smrf_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int SIDE_W     = $clog2(MAX_SIDE);
  localparam int N_W        = $clog2(MAX_SIDE + 1);
  localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int POS_W      = $clog2(DEPTH + 1);
  localparam int DIV_CNT_W  = $clog2(POS_W);
  localparam int CFG_W      = 7;
  localparam int ELEM_W     = 8;
  localparam int LETTER_W   = 8;
  localparam int OP_W       = 2;
  localparam int SIDE_RESET = 64;
  localparam int RST_N      = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE :
                              ((SIDE_RESET == 0) ? 1 : SIDE_RESET);

  localparam logic [OP_W-1:0] OP_LOAD   = OP_W'(0);
  localparam logic [OP_W-1:0] OP_LETTER = OP_W'(1);
  localparam logic [OP_W-1:0] OP_READ   = OP_W'(2);

  localparam logic [LETTER_W-1:0] LT_T = 8'h54;
  localparam logic [LETTER_W-1:0] LT_D = 8'h44;
  localparam logic [LETTER_W-1:0] LT_H = 8'h48;
  localparam logic [LETTER_W-1:0] LT_V = 8'h56;
  localparam logic [LETTER_W-1:0] LT_A = 8'h41;
  localparam logic [LETTER_W-1:0] LT_Z = 8'h5A;
  localparam logic [LETTER_W-1:0] LT_B = 8'h42;
  localparam logic [LETTER_W-1:0] LT_Y = 8'h59;
  localparam logic [LETTER_W-1:0] LT_C = 8'h43;
  localparam logic [LETTER_W-1:0] LT_X = 8'h58;

  // Dihedral index map.
  typedef struct packed {
    logic swap;
    logic flip_rows;
    logic flip_cols;
  } map_t;

  // Status of the position divider.
  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quo;
    logic [N_W-1:0]   rem;
  } div_res_t;

  // Clamp the programmed side length into 1..MAX_SIDE.
  function automatic logic [N_W-1:0] eff_side(input logic [CFG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) return N_W'(1);
    if (w > 32'(MAX_SIDE)) return N_W'(MAX_SIDE);
    return N_W'(w);
  endfunction

  // Fold one operation letter into the map.
  function automatic map_t apply_letter(input map_t m, input logic [LETTER_W-1:0] ch);
    map_t x;
    map_t r;
    x.swap      = !m.swap;
    x.flip_rows = m.flip_cols;
    x.flip_cols = m.flip_rows;
    r = m;
    unique case (ch)
      LT_T:       r = x;
      LT_D:       r = '{swap: x.swap, flip_rows: !x.flip_rows, flip_cols: !x.flip_cols};
      LT_H:       r = '{swap: m.swap, flip_rows: m.flip_rows, flip_cols: !m.flip_cols};
      LT_V:       r = '{swap: m.swap, flip_rows: !m.flip_rows, flip_cols: m.flip_cols};
      LT_A, LT_Z: r = '{swap: x.swap, flip_rows: x.flip_rows, flip_cols: !x.flip_cols};
      LT_B, LT_Y: r = '{swap: m.swap, flip_rows: !m.flip_rows, flip_cols: !m.flip_cols};
      LT_C, LT_X: r = '{swap: x.swap, flip_rows: !x.flip_rows, flip_cols: x.flip_cols};
      default:    r = m;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/square_matrix_rotate_flip.sv =====
// Top level of the square matrix rotate/flip/transpose block.
// Load and letter words are accepted back to back while no read is in flight.
// A read word holds off the input while it passes S_MUL (address multiply with RAM read),
// then S_PUT, which loads its result word into the output register once that is free.
// The first read after a side length write first passes the divider and index setup.
// Synchronous reset (rst_n low) clears counters, map and side length to 64, not the RAM.
`include "square_matrix_rotate_flip_defines.svh"

module square_matrix_rotate_flip (
  input  logic                          clk,
  input  logic                          rst_n,
  // Side length register write.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [smrf_pkg::CFG_W-1:0]    cfg_data,
  // Input words.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [7:0] element, [15:8] op_letter
  input  logic [smrf_pkg::OP_W-1:0]     in_tuser,   // [1:0] operation
  // Result words.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] out_element
  output logic                          out_tlast   // last element of the matrix
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ADDR,
    S_MUL,
    S_PUT
  } state_t;

  localparam int PROD_W = smrf_pkg::SIDE_W + smrf_pkg::N_W;

  state_t                          state_r;
  logic [smrf_pkg::N_W-1:0]        n_r;
  logic [smrf_pkg::POS_W-1:0]      total_r;
  logic [smrf_pkg::POS_W-1:0]      lp_r;
  logic [smrf_pkg::POS_W-1:0]      rpos_r;
  logic [smrf_pkg::SIDE_W-1:0]     row_r;
  logic [smrf_pkg::SIDE_W-1:0]     col_r;
  smrf_pkg::map_t                  map_r;
  logic                            resync_r;
  logic [smrf_pkg::SIDE_W-1:0]     i_r;
  logic [smrf_pkg::SIDE_W-1:0]     j_r;
  logic                            last_r;
  logic                            zero_r;
  logic                            out_valid_r;
  logic [smrf_pkg::ELEM_W-1:0]     out_data_r;
  logic                            out_last_r;

  logic                            in_acc;
  logic [smrf_pkg::ELEM_W-1:0]     in_elem;
  logic [smrf_pkg::LETTER_W-1:0]   in_letter;
  logic                            is_read;
  logic                            past_end;
  logic                            adv_last;
  logic                            rd_go;
  logic                            do_adv;
  logic                            do_clear;
  logic                            div_start;
  logic                            put_go;
  smrf_pkg::div_res_t              div_res;
  logic [smrf_pkg::N_W-1:0]        cfg_side;
  logic [2*smrf_pkg::N_W-1:0]      cfg_sq;
  logic [smrf_pkg::N_W-1:0]        n_m1;
  logic [smrf_pkg::N_W-1:0]        row_rev;
  logic [smrf_pkg::N_W-1:0]        col_rev;
  logic [smrf_pkg::SIDE_W-1:0]     row_s;
  logic [smrf_pkg::SIDE_W-1:0]     col_s;
  logic [smrf_pkg::SIDE_W-1:0]     i_nxt;
  logic [smrf_pkg::SIDE_W-1:0]     j_nxt;
  logic [PROD_W-1:0]               addr_full;
  logic                            wr_en;
  logic                            rd_en;
  logic [smrf_pkg::ELEM_W-1:0]     rd_data;

  // Handshakes. Configuration is taken only while no item is pending or offered.
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !in_tvalid;
  assign in_acc    = in_tvalid && in_tready;
  assign in_elem   = in_tdata[7:0];
  assign in_letter = in_tdata[15:8];
  assign is_read   = (in_tuser == smrf_pkg::OP_READ);

  // Effective side length and matrix size, both registered at the write.
  assign cfg_side = smrf_pkg::eff_side(cfg_data);
  assign cfg_sq   = cfg_side * cfg_side;

  // A read past the end happens only if the side shrank in mid-matrix.
  assign past_end = rpos_r >= total_r;
  assign adv_last = (rpos_r + smrf_pkg::POS_W'(1)) >= total_r;

  // Row and column of the next output element mapped back to source indices.
  assign n_m1    = n_r - smrf_pkg::N_W'(1);
  assign row_rev = n_m1 - smrf_pkg::N_W'(row_r);
  assign col_rev = n_m1 - smrf_pkg::N_W'(col_r);
  assign row_s   = map_r.flip_rows ? row_rev[smrf_pkg::SIDE_W-1:0] : row_r;
  assign col_s   = map_r.flip_cols ? col_rev[smrf_pkg::SIDE_W-1:0] : col_r;
  assign i_nxt   = map_r.swap ? col_s : row_s;
  assign j_nxt   = map_r.swap ? row_s : col_s;

  // A read goes straight to address generation unless the row and column
  // counters are stale after a side length change; then the divider rebuilds them.
  assign rd_go     = in_acc && is_read && !past_end && !resync_r;
  assign div_start = in_acc && is_read && !past_end && resync_r;
  assign do_adv    = rd_go || (state_r == S_ADDR);
  assign do_clear  = (do_adv && adv_last) || (in_acc && is_read && past_end);

  // The output register loads once RAM data is valid and the register is free.
  assign put_go = (state_r == S_PUT) && (!out_valid_r || out_tready);

  // Source address in row-major order of the loaded matrix.
  assign addr_full = (PROD_W'(i_r) * PROD_W'(n_r)) + PROD_W'(j_r);

  assign wr_en = in_acc && (in_tuser == smrf_pkg::OP_LOAD) && (lp_r < total_r);
  assign rd_en = (state_r == S_MUL);

  smrf_ram #(
    .DATA_W (smrf_pkg::ELEM_W),
    .DEPTH  (smrf_pkg::DEPTH),
    .ADDR_W (smrf_pkg::ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (lp_r[smrf_pkg::ADDR_W-1:0]),
    .wr_data (in_elem),
    .rd_en   (rd_en),
    .rd_addr (addr_full[smrf_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  smrf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rpos_r),
    .divisor  (n_r),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= smrf_pkg::N_W'(smrf_pkg::RST_N);
      total_r     <= smrf_pkg::POS_W'(smrf_pkg::RST_N * smrf_pkg::RST_N);
      lp_r        <= '0;
      rpos_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      map_r       <= '0;
      resync_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (put_go) begin
        out_valid_r <= 1'b1;
        out_data_r  <= zero_r ? '0 : rd_data;
        out_last_r  <= last_r;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        n_r      <= cfg_side;
        total_r  <= cfg_sq[smrf_pkg::POS_W-1:0];
        resync_r <= 1'b1;
      end

      // Capture source indices and step the read counters.
      if (do_adv) begin
        i_r    <= i_nxt;
        j_r    <= j_nxt;
        last_r <= adv_last;
        zero_r <= 1'b0;
        if (!adv_last) begin
          rpos_r <= rpos_r + smrf_pkg::POS_W'(1);
          if (smrf_pkg::N_W'(col_r) == n_m1) begin
            col_r <= '0;
            row_r <= row_r + smrf_pkg::SIDE_W'(1);
          end else begin
            col_r <= col_r + smrf_pkg::SIDE_W'(1);
          end
        end
      end

      // End of matrix: counters and map return to their start.
      if (do_clear) begin
        lp_r     <= '0;
        rpos_r   <= '0;
        row_r    <= '0;
        col_r    <= '0;
        map_r    <= '0;
        resync_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_tuser)
              smrf_pkg::OP_LOAD: begin
                if (lp_r < total_r) begin
                  lp_r <= lp_r + smrf_pkg::POS_W'(1);
                end
              end
              smrf_pkg::OP_LETTER: begin
                map_r <= smrf_pkg::apply_letter(map_r, in_letter);
              end
              smrf_pkg::OP_READ: begin
                if (past_end) begin
                  zero_r  <= 1'b1;
                  last_r  <= 1'b1;
                  state_r <= S_PUT;
                end else if (resync_r) begin
                  state_r <= S_DIV;
                end else begin
                  state_r <= S_MUL;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            row_r    <= div_res.quo[smrf_pkg::SIDE_W-1:0];
            col_r    <= div_res.rem[smrf_pkg::SIDE_W-1:0];
            resync_r <= 1'b0;
            state_r  <= S_ADDR;
          end
        end
        S_ADDR: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_PUT;
        end
        S_PUT: begin
          // RAM data is valid here; wait until the output register is free.
          if (put_go) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // The divider only finishes while the read waits on it.
  `SMRF_ASSERT_IMP(a_div_done_in_div, div_res.done, state_r == S_DIV)
  // An accepted read holds off the next input word.
  `SMRF_ASSERT_NEXT(a_read_blocks_input, in_acc && is_read, !in_tready)
  // Mapped source address always lies inside the loaded matrix.
  `SMRF_ASSERT_IMP(a_addr_in_matrix, rd_en, addr_full < PROD_W'(total_r))

endmodule

// ===== rtl/smrf_ram.sv =====
// Simple dual-port synchronous RAM with registered read.
module smrf_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/smrf_div.sv =====
// Restoring divider that splits a linear read position into row and column.
module smrf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [smrf_pkg::POS_W-1:0]  dividend,
  input  logic [smrf_pkg::N_W-1:0]    divisor,
  output smrf_pkg::div_res_t          res
);

  logic                            busy_r;
  logic                            done_r;
  logic [smrf_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [smrf_pkg::POS_W-1:0]      dvd_r;
  logic [smrf_pkg::N_W-1:0]        rem_r;
  logic [smrf_pkg::N_W-1:0]        dvs_r;
  logic [smrf_pkg::N_W:0]          shifted;
  logic [smrf_pkg::N_W:0]          diff;
  logic                            fits;

  // One quotient bit per cycle, most significant first.
  assign shifted = {rem_r, dvd_r[smrf_pkg::POS_W-1]};
  assign fits    = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[smrf_pkg::POS_W-2:0], fits};
        rem_r <= fits ? diff[smrf_pkg::N_W-1:0] : shifted[smrf_pkg::N_W-1:0];
        cnt_r <= cnt_r + smrf_pkg::DIV_CNT_W'(1);
        if (cnt_r == smrf_pkg::DIV_CNT_W'(smrf_pkg::POS_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quo  = dvd_r;
  assign res.rem  = rem_r;

endmodule

// ===== tb/sv/square_matrix_rotate_flip_test.sv =====
// Self-checking testbench of the square matrix rotate/flip block with its own predictor.
module square_matrix_rotate_flip_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation code 3 is unused by the block; it must be swallowed silently.
  localparam logic [smrf_pkg::OP_W-1:0]     OP_UNUSED  = smrf_pkg::OP_W'(3);
  // A lowercase letter that means nothing to the block.
  localparam logic [smrf_pkg::LETTER_W-1:0] LT_UNKNOWN = 8'h71;

  // The first read after a side length write passes through the divider; this many
  // quiet cycles are enough for any word still in flight.
  localparam int SETTLE_CYCLES   = 24;
  localparam int IDLE_LIMIT      = 5000;
  localparam int RANDOM_WORDS    = 350;
  localparam int FULL_SIDE_WORDS = 24;
  localparam int REPORT_LIMIT    = 10;
  localparam int OWED_DEPTH      = 8;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [smrf_pkg::CFG_W-1:0]    cfg_data;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [15:0]                   in_tdata;   // [7:0] element, [15:8] op_letter
  logic [smrf_pkg::OP_W-1:0]     in_tuser;   // [1:0] operation
  logic                          out_tvalid;
  logic                          out_tready;
  logic [7:0]                    out_tdata;  // [7:0] out_element
  logic                          out_tlast;

  square_matrix_rotate_flip dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // One transformed element as it should leave the block.
  typedef struct packed {
    logic [7:0] element;
    logic       last;
  } result_t;

  // One row of the directed table. A row either writes the side length or sends
  // one input word; for a few reads the expected element is spelled out.
  typedef struct packed {
    bit                         is_cfg;
    logic [smrf_pkg::CFG_W-1:0] cfg_value;
    logic [smrf_pkg::OP_W-1:0]  op;
    logic [7:0]                 elem;
    logic [7:0]                 letter;
    bit                         typed;
    logic [7:0]                 want_elem;
    bit                         want_last;
  } step_t;

  // The directed part runs on a 2x2 matrix. Loads cover both byte extremes, a
  // fifth load lands past the end and must be dropped, and the unused code is
  // sent with all ones. Three reads of the untouched map give the loaded order.
  // Shrinking the side to 1 in mid-matrix leaves the read position past the end,
  // so the next read returns zero with the last flag and restarts the matrix.
  // Then, at side 2 again, every known letter but T and H, plus an unknown one, is folded into one map.
  step_t directed_steps [26] = '{
    '{1'b1, 7'd2, smrf_pkg::OP_LOAD,   8'h00, 8'h00,          1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_LOAD,   8'h00, 8'h00,          1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_LOAD,   8'hFF, 8'h00,          1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_LOAD,   8'h5A, 8'h00,          1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_LOAD,   8'hA5, 8'h00,          1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_LOAD,   8'h33, 8'h00,          1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, OP_UNUSED,           8'hFF, 8'hFF,          1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_READ,   8'h00, 8'h00,          1'b1, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_READ,   8'h00, 8'h00,          1'b1, 8'hFF, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_READ,   8'h00, 8'h00,          1'b1, 8'h5A, 1'b0},
    '{1'b1, 7'd1, smrf_pkg::OP_LOAD,   8'h00, 8'h00,          1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_READ,   8'h00, 8'h00,          1'b1, 8'h00, 1'b1},
    '{1'b1, 7'd2, smrf_pkg::OP_LOAD,   8'h00, 8'h00,          1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_LETTER, 8'h00, smrf_pkg::LT_D, 1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_LETTER, 8'h00, smrf_pkg::LT_V, 1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_LETTER, 8'h00, smrf_pkg::LT_A, 1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_LETTER, 8'h00, smrf_pkg::LT_Z, 1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_LETTER, 8'h00, smrf_pkg::LT_B, 1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_LETTER, 8'h00, smrf_pkg::LT_Y, 1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_LETTER, 8'h00, smrf_pkg::LT_C, 1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_LETTER, 8'h00, smrf_pkg::LT_X, 1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_LETTER, 8'h00, LT_UNKNOWN,     1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_READ,   8'h00, 8'h00,          1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_READ,   8'h00, 8'h00,          1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_READ,   8'h00, 8'h00,          1'b0, 8'h00, 1'b0},
    '{1'b0, 7'd0, smrf_pkg::OP_READ,   8'h00, 8'h00,          1'b0, 8'h00, 1'b0}
  };

  logic [smrf_pkg::LETTER_W-1:0] known_letters [10] = '{
    smrf_pkg::LT_T, smrf_pkg::LT_D, smrf_pkg::LT_H, smrf_pkg::LT_V, smrf_pkg::LT_A,
    smrf_pkg::LT_Z, smrf_pkg::LT_B, smrf_pkg::LT_Y, smrf_pkg::LT_C, smrf_pkg::LT_X
  };

  // Elements still owed by the block, oldest first, kept in a small ring.
  result_t owed_words [OWED_DEPTH];
  int      owed_head;
  int      owed_tail;
  int      owed_count;

  // Predictor copy of the block state. elem_loaded marks every store entry that
  // has ever been written, so the stimulus never reads an undefined entry.
  logic [smrf_pkg::CFG_W-1:0] side_reg;
  int                         load_pos;
  int                         read_pos;
  smrf_pkg::map_t             view_map;
  logic [7:0]                 elem_mem [smrf_pkg::DEPTH];
  bit                         elem_loaded [smrf_pkg::DEPTH];

  int mismatch_count;
  int word_count;
  int quiet_cycles;
  bit steady_sender;

  // The side length register is clamped into 1..MAX_SIDE when used.
  function automatic int side_in_use();
    if (side_reg == '0) return 1;
    if (int'(side_reg) > smrf_pkg::MAX_SIDE) return smrf_pkg::MAX_SIDE;
    return int'(side_reg);
  endfunction

  // Store address the next read fetches from, or -1 once the read position has
  // run past the end of the current matrix.
  function automatic int source_addr();
    int n;
    int row;
    int col;
    n = side_in_use();
    if (read_pos >= n * n) return -1;
    row = read_pos / n;
    col = read_pos % n;
    if (view_map.flip_rows) row = n - 1 - row;
    if (view_map.flip_cols) col = n - 1 - col;
    return view_map.swap ? col * n + row : row * n + col;
  endfunction

  function automatic bit read_is_safe();
    int addr;
    addr = source_addr();
    return (addr < 0) || elem_loaded[addr];
  endfunction

  // Each letter is an optional turn (exchange the axes, which also trades the two
  // reversal bits) followed by optional reversals of the row and/or column index.
  function automatic smrf_pkg::map_t fold_letter(smrf_pkg::map_t m,
                                                 logic [smrf_pkg::LETTER_W-1:0] ch);
    smrf_pkg::map_t r;
    bit             turn;
    bit             rev_x;
    bit             rev_y;
    turn  = 1'b0;
    rev_x = 1'b0;
    rev_y = 1'b0;
    case (ch)
      smrf_pkg::LT_T:                  turn = 1'b1;
      smrf_pkg::LT_D:                  begin turn = 1'b1; rev_x = 1'b1; rev_y = 1'b1; end
      smrf_pkg::LT_H:                  rev_y = 1'b1;
      smrf_pkg::LT_V:                  rev_x = 1'b1;
      smrf_pkg::LT_A, smrf_pkg::LT_Z:  begin turn = 1'b1; rev_y = 1'b1; end
      smrf_pkg::LT_B, smrf_pkg::LT_Y:  begin rev_x = 1'b1; rev_y = 1'b1; end
      smrf_pkg::LT_C, smrf_pkg::LT_X:  begin turn = 1'b1; rev_x = 1'b1; end
      default:                         ;
    endcase
    r = m;
    if (turn) begin
      r.swap      = !m.swap;
      r.flip_rows = m.flip_cols;
      r.flip_cols = m.flip_rows;
    end
    r.flip_rows = r.flip_rows ^ rev_x;
    r.flip_cols = r.flip_cols ^ rev_y;
    return r;
  endfunction

  // Advance the predictor by one accepted word; returns 1 when the word owes a
  // transformed element, which is handed back in res.
  function automatic bit predict_transformed(logic [smrf_pkg::OP_W-1:0] op,
                                             logic [7:0] elem, logic [7:0] letter,
                                             output result_t res);
    int n;
    int addr;
    bit finished;
    n        = side_in_use();
    res      = '0;
    finished = 1'b0;
    case (op)
      smrf_pkg::OP_LOAD: begin
        if (load_pos < n * n) begin
          elem_mem[load_pos]    = elem;
          elem_loaded[load_pos] = 1'b1;
          load_pos++;
        end
      end
      smrf_pkg::OP_LETTER: view_map = fold_letter(view_map, letter);
      smrf_pkg::OP_READ: begin
        addr = source_addr();
        if (addr < 0) begin
          res.last = 1'b1;
          finished = 1'b1;
        end else begin
          res.element = elem_mem[addr];
          if (read_pos + 1 >= n * n) begin
            res.last = 1'b1;
            finished = 1'b1;
          end else begin
            read_pos++;
          end
        end
      end
      default: ;
    endcase
    if (finished) begin
      load_pos = 0;
      read_pos = 0;
      view_map = '0;
    end
    return op == smrf_pkg::OP_READ;
  endfunction

  // Sender gaps: mostly none or short, now and then a long one. A phase may
  // run the sender without any gaps at all.
  function automatic int pick_gap();
    int r;
    if (steady_sender) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 5) == 0) return 8'($urandom);
    return known_letters[$urandom_range(0, 9)];
  endfunction

  // Present one word after a random gap and hold it until the block takes it.
  // Valid stays high past acceptance so back-to-back words need no extra edge;
  // every waiting point lowers it first.
  task automatic send_word(input logic [smrf_pkg::OP_W-1:0] op, input logic [7:0] elem,
                           input logic [7:0] letter, input bit typed = 1'b0,
                           input result_t typed_res = '0);
    int      gap;
    result_t res;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {letter, elem};
    do @(posedge clk); while (!in_tready);
    if (predict_transformed(op, elem, letter, res)) begin
      owed_words[owed_tail] = typed ? typed_res : res;
      owed_tail             = (owed_tail + 1) % OWED_DEPTH;
      owed_count++;
    end
    if (op != OP_UNUSED) word_count++;
  endtask

  // Stop sending and wait until every owed element has come out.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (owed_count != 0) @(posedge clk);
  endtask

  // The side length may only change while the block is idle.
  task automatic write_side(input logic [smrf_pkg::CFG_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    side_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One read, or a load in its place when the read would fetch an entry
  // never written.
  task automatic safe_read();
    if (read_is_safe())
      send_word(smrf_pkg::OP_READ, 8'($urandom), 8'($urandom));
    else
      send_word(smrf_pkg::OP_LOAD, 8'($urandom), 8'($urandom));
  endtask

  // One matrix as a user would send it, with noise mixed in: stray letters and
  // unused codes during the load, early reads, loads past the end, and now and
  // then a read-out that stops partway. A read that would fetch an entry never
  // written is replaced by a load, which always fills the matrix in the end.
  task automatic run_matrix();
    int total;
    int pick;
    int reads;
    total = side_in_use() * side_in_use();
    while (load_pos < total) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        send_word(OP_UNUSED, 8'($urandom), 8'($urandom));
      else if (pick == 1)
        send_word(smrf_pkg::OP_LETTER, 8'($urandom), 8'($urandom));
      else if (pick == 2 && read_is_safe())
        send_word(smrf_pkg::OP_READ, 8'($urandom), 8'($urandom));
      else
        send_word(smrf_pkg::OP_LOAD, 8'($urandom), 8'($urandom));
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        send_word(smrf_pkg::OP_LOAD, 8'($urandom), 8'($urandom));
    repeat ($urandom_range(0, 4))
      send_word(smrf_pkg::OP_LETTER, 8'($urandom), pick_letter());
    // Sometimes hold the sender back until the block has caught up.
    if ($urandom_range(0, 7) == 0) drain_results();
    reads = ($urandom_range(0, 5) == 0) ? $urandom_range(1, total) : total;
    repeat (reads) safe_read();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side back-pressure: short stalls, a few long ones, and long
  // stretches of steady acceptance.
  initial begin
    int pick;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(10, 50)) @(negedge clk);
      end else if (pick < 3) begin
        out_tready = 1'b1;
        repeat ($urandom_range(40, 150)) @(negedge clk);
      end else begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
        out_tready = 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  end

  // Compare every result word with the oldest owed element.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_count == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("%0t: unexpected word element=%02h last=%0b", $realtime,
                   out_tdata, out_tlast);
        mismatch_count++;
      end else begin
        want      = owed_words[owed_head];
        owed_head = (owed_head + 1) % OWED_DEPTH;
        owed_count--;
        if (out_tdata !== want.element || out_tlast !== want.last) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: element expected %02h got %02h, last expected %0b got %0b",
                     $realtime, want.element, out_tdata, want.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hung block shows up as a long run of cycles with no handshake.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase;
    int random_start;
    logic [smrf_pkg::CFG_W-1:0] side_value;
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = smrf_pkg::OP_LOAD;
    quiet_cycles   = 0;
    mismatch_count = 0;
    word_count     = 0;
    owed_head      = 0;
    owed_tail      = 0;
    owed_count     = 0;
    steady_sender  = 1'b0;
    side_reg       = smrf_pkg::CFG_W'(smrf_pkg::SIDE_RESET);
    load_pos       = 0;
    read_pos       = 0;
    view_map       = '0;
    foreach (elem_loaded[i]) elem_loaded[i] = 1'b0;
    foreach (elem_mem[i]) elem_mem[i] = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg)
        write_side(directed_steps[i].cfg_value);
      else
        send_word(directed_steps[i].op, directed_steps[i].elem, directed_steps[i].letter,
                  directed_steps[i].typed,
                  '{directed_steps[i].want_elem, directed_steps[i].want_last});
    end

    // Random phases on small matrices. The first two use a zero side length
    // (treated as one) and a side of one; later ones mostly stay small.
    random_start = word_count;
    phase        = 0;
    while (word_count - random_start < RANDOM_WORDS) begin
      if (phase == 0)
        side_value = '0;
      else if (phase == 1)
        side_value = smrf_pkg::CFG_W'(1);
      else if ($urandom_range(0, 9) == 0)
        side_value = smrf_pkg::CFG_W'($urandom_range(6, 8));
      else
        side_value = smrf_pkg::CFG_W'($urandom_range(2, 5));
      steady_sender = ($urandom_range(0, 3) == 0);
      write_side(side_value);
      repeat ($urandom_range(1, 3)) run_matrix();
      phase++;
    end

    // Every register bit set clamps to the largest side; a short read-out then
    // walks the start of the full-size matrix with its wide row stride.
    steady_sender = 1'b1;
    write_side('1);
    repeat (FULL_SIDE_WORDS) safe_read();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && owed_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== square_matrix_rotate_flip.f =====
+incdir+rtl
rtl/smrf_pkg.sv
rtl/smrf_ram.sv
rtl/smrf_div.sv
rtl/square_matrix_rotate_flip.sv
tb/sv/square_matrix_rotate_flip_test.sv
